// ----- sv/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types, codes and defaults of the buddy page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int NUM_PAGES_DEF  = 4096;
    localparam int TOP_ORDER_DEF  = 10;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam int CNT_W     = 13;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int ORD_W     = 5;
    localparam int WIDE_W    = 18;

    localparam logic [CNT_W-1:0] COUNT_MAX    = 13'd8191;
    localparam logic [CNT_W-1:0] MANAGED_RST  = 13'd4096;
    localparam logic [33:0]      HEADER_BYTES = 34'd8;

    localparam logic [1:0] OP_ALLOC_BYTES = 2'd0;
    localparam logic [1:0] OP_ALLOC_PAGE  = 2'd1;
    localparam logic [1:0] OP_FREE        = 2'd2;
    localparam logic [1:0] OP_INIT        = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] request_bytes;
        logic [11:0] block_page;
        logic [3:0]  free_order;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [11:0]      alloc_page;
        logic [3:0]       alloc_order;
        logic [CNT_W-1:0] free_pages;
        logic [CNT_W-1:0] total_pages;
    } t_out;

endpackage

// ----- sv/bpa_map_ram.sv -----
// ----------------------------------------------------------------------------
// bpa_map_ram
// single port word memory holding the free bits of all orders
// ----------------------------------------------------------------------------
module bpa_map_ram
    import bpa_pkg::*;
#(
    parameter int AW = 8
) (
    input  logic              i_clk,
    input  logic [AW-1:0]     i_addr,
    input  logic              i_we,
    input  logic [WORD_W-1:0] i_wdata,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [2**AW];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bpa_pick.sv -----
// ----------------------------------------------------------------------------
// bpa_pick
// lowest set bit of a map word, bits below a start position masked off when i_first is set
// ----------------------------------------------------------------------------
module bpa_pick
    import bpa_pkg::*;
(
    input  logic [WORD_W-1:0] i_data,
    input  logic [BIT_W-1:0]  i_lo,
    input  logic              i_first,
    output logic              o_hit,
    output logic [BIT_W-1:0]  o_idx
);

    logic [WORD_W-1:0] masked;

    always_comb begin
        masked = i_data;
        if (i_first) begin
            masked = i_data & ~((WORD_W'(1) << i_lo) - WORD_W'(1));
        end
        o_hit = |masked;
        o_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (masked[i]) begin
                o_idx = BIT_W'(i);
            end
        end
    end

endmodule

// ----- sv/buddy_page_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_page_allocator
// buddy allocator over a page indexed region, free bits kept in one memory
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_data) takes one operation:
//   allocate bytes, allocate page, free block or initialize. each transaction
//   gives exactly one result transaction on o_out_valid / i_out_stall.
//   one operation is worked at a time; o_in_stall is high while it runs.
//   steps: allocate bytes takes a size step per order; both allocates then scan
//   the map one 32 bit word at a time from the requested order upward (up to
//   2*NUM_PAGES/32 words), then do a read-modify-write per split. free checks
//   and clears the buddy bit per merge level, then sets its own bit by a
//   read-modify-write. initialize clears the whole map (2*NUM_PAGES/32 words,
//   256 by default), then tiles it by read-modify-writes, stepping orders down.
//   all work runs through the single map memory port.
//   after reset the same clearing pass runs before the first transaction is
//   taken; i_cfg_we writes managed_pages at any time.
//   a result waiting under i_out_stall does not block the next transaction;
//   the one after waits until the output register is free.
// ----------------------------------------------------------------------------
module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int TOP_ORDER  = TOP_ORDER_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data
);

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int BAW = PW + 1;
    localparam int AW  = BAW - BIT_W;
    localparam logic [AW-1:0]     ADDR_MAX = {AW{1'b1}};
    localparam logic [BAW:0]      TWO_N    = (BAW+1)'(2 * NUM_PAGES);
    localparam logic [WIDE_W-1:0] N_WIDE   = WIDE_W'(NUM_PAGES);
    localparam logic [ORD_W-1:0]  TOP      = ORD_W'(TOP_ORDER);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_CLEAR    = 14'b00000000000010,
        S_SIZE     = 14'b00000000000100,
        S_TAKE     = 14'b00000000001000,
        S_SRCH_RD  = 14'b00000000010000,
        S_SRCH_CHK = 14'b00000000100000,
        S_FOUND    = 14'b00000001000000,
        S_SPLIT    = 14'b00000010000000,
        S_RMW_RD   = 14'b00000100000000,
        S_RMW_WR   = 14'b00001000000000,
        S_MERGE    = 14'b00010000000000,
        S_M_RD     = 14'b00100000000000,
        S_M_CHK    = 14'b01000000000000,
        S_TILE     = 14'b10000000000000
    } t_state;

    // S_DONE folded into a flag so the result stage stays separate
    t_state r_state, n_state, r_ret, n_ret;
    logic              r_done, n_done;
    logic [AW-1:0]     r_addr, n_addr;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic              r_first, n_first;
    logic [ORD_W-1:0]  r_order, n_order;
    logic [ORD_W-1:0]  r_found, n_found;
    logic [PW-1:0]     r_page, n_page;
    logic [BAW-1:0]    r_bitaddr, n_bitaddr;
    logic [CNT_W-1:0]  r_fpc, n_fpc;
    logic [CNT_W-1:0]  r_tpc, n_tpc;
    logic [CNT_W-1:0]  r_managed;
    logic [PW:0]       r_cursor, n_cursor;
    logic [WIDE_W-1:0] r_remain, n_remain;
    logic [33:0]       r_need, n_need;
    logic [1:0]        r_status, n_status;
    logic [11:0]       r_apage, n_apage;
    logic [3:0]        r_aorder, n_aorder;
    t_out              r_out, n_out;
    logic              r_ovalid, n_ovalid;

    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic              pick_hit;
    logic [BIT_W-1:0]  pick_idx;

    function automatic logic [BAW:0] f_off(input logic [ORD_W-1:0] o);
        f_off = TWO_N - (TWO_N >> o);
    endfunction

    function automatic logic [BAW-1:0] f_baddr(input logic [ORD_W-1:0] o,
                                               input logic [PW-1:0] p);
        logic [BAW:0] s;
        s = f_off(o) + (BAW+1)'(p >> o);
        f_baddr = s[BAW-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] f_add(input logic [CNT_W-1:0] c,
                                               input logic [ORD_W-1:0] o);
        logic [WIDE_W-1:0] s;
        s = WIDE_W'(c) + (WIDE_W'(1) << o);
        f_add = (s > WIDE_W'(COUNT_MAX)) ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] f_sub(input logic [CNT_W-1:0] c,
                                               input logic [ORD_W-1:0] o);
        logic [WIDE_W-1:0] a;
        a = WIDE_W'(1) << o;
        f_sub = (WIDE_W'(c) >= a) ? CNT_W'(WIDE_W'(c) - a) : '0;
    endfunction

    bpa_map_ram #(
        .AW (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_addr  (r_addr),
        .i_we    (ram_we),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    bpa_pick u_pick (
        .i_data  (ram_rdata),
        .i_lo    (r_bit),
        .i_first (r_first),
        .o_hit   (pick_hit),
        .o_idx   (pick_idx)
    );

    always_comb begin
        logic [BAW:0]      s;
        logic [BAW-1:0]    ba;
        logic [ORD_W-1:0]  h;
        logic [ORD_W-1:0]  f;
        logic [BAW:0]      rel;
        logic [WIDE_W-1:0] buddy;
        logic [WIDE_W-1:0] size;
        logic [WIDE_W-1:0] lim;
        logic [16:0]       amask;
        logic              bad;

        n_state   = r_state;
        n_ret     = r_ret;
        n_done    = r_done;
        n_addr    = r_addr;
        n_bit     = r_bit;
        n_first   = r_first;
        n_order   = r_order;
        n_found   = r_found;
        n_page    = r_page;
        n_bitaddr = r_bitaddr;
        n_fpc     = r_fpc;
        n_tpc     = r_tpc;
        n_cursor  = r_cursor;
        n_remain  = r_remain;
        n_need    = r_need;
        n_status  = r_status;
        n_apage   = r_apage;
        n_aorder  = r_aorder;
        n_out     = r_out;
        n_ovalid  = r_ovalid;
        ram_we    = 1'b0;
        ram_wdata = ram_rdata;
        s         = '0;
        ba        = '0;
        h         = '0;
        f         = '0;
        rel       = '0;
        buddy     = '0;
        size      = '0;
        lim       = '0;
        amask     = '0;
        bad       = 1'b0;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        if (r_done) begin
            if (!r_ovalid || !i_out_stall) begin
                n_out    = '{status: r_status, alloc_page: r_apage, alloc_order: r_aorder,
                             free_pages: r_fpc, total_pages: r_tpc};
                n_ovalid = 1'b1;
                n_done   = 1'b0;
                n_state  = S_IDLE;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        n_status = ST_OK;
                        n_apage  = '0;
                        n_aorder = '0;
                        n_order  = '0;
                        unique case (i_in_data.opcode)
                            OP_ALLOC_BYTES: begin
                                if (i_in_data.request_bytes == '0) begin
                                    n_status = ST_BAD;
                                    n_done   = 1'b1;
                                end else begin
                                    n_need  = 34'(i_in_data.request_bytes) + HEADER_BYTES;
                                    n_state = S_SIZE;
                                end
                            end
                            OP_ALLOC_PAGE: begin
                                n_state = S_TAKE;
                            end
                            OP_FREE: begin
                                amask = (17'd1 << i_in_data.free_order) - 17'd1;
                                lim   = WIDE_W'(i_in_data.block_page)
                                      + (WIDE_W'(1) << i_in_data.free_order);
                                bad   = (ORD_W'(i_in_data.free_order) > TOP)
                                     || ((17'(i_in_data.block_page) & amask) != '0)
                                     || (lim > N_WIDE);
                                if (bad) begin
                                    n_status = ST_BAD;
                                    n_done   = 1'b1;
                                end else begin
                                    n_fpc   = f_add(r_fpc, ORD_W'(i_in_data.free_order));
                                    n_page  = PW'(i_in_data.block_page);
                                    n_order = ORD_W'(i_in_data.free_order);
                                    n_state = S_MERGE;
                                end
                            end
                            OP_INIT: begin
                                n_fpc    = '0;
                                n_remain = (WIDE_W'(r_managed) > N_WIDE) ? N_WIDE
                                         : WIDE_W'(r_managed);
                                n_cursor = '0;
                                n_order  = TOP;
                                n_addr   = '0;
                                n_ret    = S_TILE;
                                n_state  = S_CLEAR;
                            end
                            default: n_state = S_IDLE;
                        endcase
                    end
                end
                S_CLEAR: begin
                    ram_we    = 1'b1;
                    ram_wdata = '0;
                    if (r_addr == ADDR_MAX) begin
                        n_addr  = '0;
                        n_state = r_ret;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                S_SIZE: begin
                    if (r_order > TOP) begin
                        n_status = ST_NOFIT;
                        n_done   = 1'b1;
                    end else if ((64'(PAGE_BYTES) << r_order) < 64'(r_need)) begin
                        n_order = r_order + ORD_W'(1);
                    end else begin
                        n_state = S_TAKE;
                    end
                end
                S_TAKE: begin
                    s = f_off(r_order);
                    if (r_order > TOP || s[BAW]) begin
                        n_status = ST_NOFIT;
                        n_done   = 1'b1;
                    end else begin
                        n_addr  = s[BAW-1:BIT_W];
                        n_bit   = s[BIT_W-1:0];
                        n_first = 1'b1;
                        n_state = S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    n_state = S_SRCH_CHK;
                end
                S_SRCH_CHK: begin
                    if (pick_hit) begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~(WORD_W'(1) << pick_idx);
                        n_bitaddr = {r_addr, pick_idx};
                        n_state   = S_FOUND;
                    end else if (r_addr == ADDR_MAX) begin
                        n_status = ST_NOFIT;
                        n_done   = 1'b1;
                    end else begin
                        n_addr  = r_addr + AW'(1);
                        n_first = 1'b0;
                        n_state = S_SRCH_RD;
                    end
                end
                S_FOUND: begin
                    for (int k = 1; k <= TOP_ORDER; k++) begin
                        if (f_off(ORD_W'(k)) <= (BAW+1)'(r_bitaddr)) begin
                            f = ORD_W'(k);
                        end
                    end
                    rel     = (BAW+1)'(r_bitaddr) - f_off(f);
                    n_found = f;
                    n_page  = PW'(rel << f);
                    n_fpc   = f_sub(r_fpc, r_order);
                    n_state = S_SPLIT;
                end
                S_SPLIT: begin
                    if (r_found > r_order) begin
                        h       = r_found - ORD_W'(1);
                        ba      = f_baddr(h, r_page + (PW'(1) << h));
                        n_addr  = ba[BAW-1:BIT_W];
                        n_bit   = ba[BIT_W-1:0];
                        n_found = h;
                        n_ret   = S_SPLIT;
                        n_state = S_RMW_RD;
                    end else begin
                        n_apage  = 12'(r_page);
                        n_aorder = 4'(r_order);
                        n_done   = 1'b1;
                    end
                end
                S_RMW_RD: begin
                    n_state = S_RMW_WR;
                end
                S_RMW_WR: begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | (WORD_W'(1) << r_bit);
                    if (r_ret == S_IDLE) begin
                        n_done = 1'b1;
                    end
                    n_state = r_ret;
                end
                S_MERGE: begin
                    buddy = WIDE_W'(r_page) ^ (WIDE_W'(1) << r_order);
                    if (r_order < TOP && buddy < N_WIDE) begin
                        ba      = f_baddr(r_order, buddy[PW-1:0]);
                        n_state = S_M_RD;
                    end else begin
                        ba      = f_baddr(r_order, r_page);
                        n_ret   = S_IDLE;
                        n_state = S_RMW_RD;
                    end
                    n_addr = ba[BAW-1:BIT_W];
                    n_bit  = ba[BIT_W-1:0];
                end
                S_M_RD: begin
                    n_state = S_M_CHK;
                end
                S_M_CHK: begin
                    if (ram_rdata[r_bit]) begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~(WORD_W'(1) << r_bit);
                        n_page    = r_page & ~PW'(WIDE_W'(1) << r_order);
                        n_order   = r_order + ORD_W'(1);
                        n_state   = S_MERGE;
                    end else begin
                        ba      = f_baddr(r_order, r_page);
                        n_addr  = ba[BAW-1:BIT_W];
                        n_bit   = ba[BIT_W-1:0];
                        n_ret   = S_IDLE;
                        n_state = S_RMW_RD;
                    end
                end
                S_TILE: begin
                    size = WIDE_W'(1) << r_order;
                    if (r_remain >= size) begin
                        ba       = f_baddr(r_order, r_cursor[PW-1:0]);
                        n_addr   = ba[BAW-1:BIT_W];
                        n_bit    = ba[BIT_W-1:0];
                        n_fpc    = f_add(r_fpc, r_order);
                        n_cursor = r_cursor + (PW+1)'(size);
                        n_remain = r_remain - size;
                        n_ret    = S_TILE;
                        n_state  = S_RMW_RD;
                    end else if (r_order == '0) begin
                        n_tpc  = r_fpc;
                        n_done = 1'b1;
                    end else begin
                        n_order = r_order - ORD_W'(1);
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_ret     <= S_IDLE;
            r_done    <= 1'b0;
            r_addr    <= '0;
            r_fpc     <= '0;
            r_tpc     <= '0;
            r_managed <= MANAGED_RST;
            r_ovalid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_done   <= n_done;
            r_addr   <= n_addr;
            r_fpc    <= n_fpc;
            r_tpc    <= n_tpc;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_managed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit     <= n_bit;
        r_first   <= n_first;
        r_order   <= n_order;
        r_found   <= n_found;
        r_page    <= n_page;
        r_bitaddr <= n_bitaddr;
        r_cursor  <= n_cursor;
        r_remain  <= n_remain;
        r_need    <= n_need;
        r_status  <= n_status;
        r_apage   <= n_apage;
        r_aorder  <= n_aorder;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE) || r_done;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule
